/* rtl/vcf_genotype_line_parser_defines.svh */
// Assertion macros shared by the parser modules.
// Each macro takes a label, a property expression and a message string.
`ifndef VCF_GENOTYPE_LINE_PARSER_DEFINES_SVH
`define VCF_GENOTYPE_LINE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside of reset.
`define VCFGT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define VCFGT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`else

`define VCFGT_ASSERT(lbl, prop, msg)

`define VCFGT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/vcfgt_pkg.sv */
`timescale 1ns / 1ps

package vcfgt_pkg;

    // Default size of the sample selection memory.
    localparam int MAX_SAMPLE_COLUMNS = 4096;

    // Field index of the first sample column.
    localparam logic [12:0] FIRST_SAMPLE_FIELD = 13'd9;
    localparam logic [12:0] FIELD_MAX          = 13'd8191;

    // Field indexes with a fixed meaning.
    localparam logic [12:0] FLD_CHROM  = 13'd0;
    localparam logic [12:0] FLD_POS    = 13'd1;
    localparam logic [12:0] FLD_REF    = 13'd3;
    localparam logic [12:0] FLD_ALT    = 13'd4;
    localparam logic [12:0] FLD_FORMAT = 13'd8;

    // Characters the parser looks for.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_T     = 8'h54;

    localparam logic [30:0] POS_MAX = 31'h7FFF_FFFF;

    // Request types on the input stream.
    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_TABLE = 1'b1;

    // Result kinds.
    localparam logic [1:0] RK_CHROM  = 2'd0;
    localparam logic [1:0] RK_GENO   = 2'd1;
    localparam logic [1:0] RK_RECORD = 2'd2;

    // Line status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FORMAT = 2'd2;

    // Output queue depth; the parser needs room for two words per byte.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  chrom_byte;
        logic [11:0] sample_ordinal;
        logic        hap_first;
        logic        hap_second;
        logic        unknown;
        logic        unphased;
        logic [30:0] position;
        logic [7:0]  ref_base;
        logic [7:0]  alt_base;
        logic [1:0]  status;
        logic        last;
    } t_result;

    // Words produced by one accepted byte.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r1;
        t_result    r0;
    } t_push;

endpackage

/* rtl/vcfgt_sel_table.sv */
`timescale 1ns / 1ps

// Sample selection memory: one bit per sample column, one write and one
// registered read per cycle, cleared by a sweep after reset.
module vcfgt_sel_table #(
    parameter int DEPTH  = vcfgt_pkg::MAX_SAMPLE_COLUMNS,
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic              i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic              o_rdata,
    output logic              o_busy
);

    logic              r_mem [DEPTH];
    logic              r_rdata;
    logic              r_fwd;
    logic              r_fwd_data;
    logic              r_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic              w_wdata;

    // The clearing sweep owns the write port until it is done.
    assign w_we    = r_busy | i_we;
    assign w_waddr = r_busy ? r_clr_addr : i_waddr;
    assign w_wdata = r_busy ? 1'b0 : i_wdata;

    // Clearing sweep control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Memory array with a registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // A write to the address being read in the same cycle wins over the old data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= w_we && (w_waddr == i_raddr);
        end
        r_fwd_data <= w_wdata;
    end

    assign o_rdata = r_fwd ? r_fwd_data : r_rdata;
    assign o_busy  = r_busy;

endmodule

/* rtl/vcfgt_out_queue.sv */
`timescale 1ns / 1ps
`include "vcf_genotype_line_parser_defines.svh"

// Result queue: takes up to two words per cycle, hands out one.
module vcfgt_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vcfgt_pkg::t_push    i_push,
    output logic                o_ready,
    output logic                o_valid,
    output vcfgt_pkg::t_result  o_head,
    input  logic                i_ready
);

    localparam int DEPTH = vcfgt_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    vcfgt_pkg::t_result r_q [DEPTH];
    logic [PW-1:0]      r_rd;
    logic [PW-1:0]      r_wr;
    logic [PW:0]        r_count;

    logic               w_pop;
    logic [PW:0]        w_push_n;

    assign w_pop    = o_valid && i_ready;
    assign w_push_n = (PW + 1)'(i_push.cnt);

    // Room for the two words a single byte can cause.
    assign o_ready = (r_count <= (PW + 1)'(DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_head  = r_q[r_rd];

    // Storage of the queued words.
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_q[r_wr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_q[r_wr + 1'b1] <= i_push.r1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PW'(i_push.cnt);
            r_rd    <= r_rd + PW'(w_pop);
            r_count <= r_count + w_push_n - (PW + 1)'(w_pop);
        end
    end

    `VCFGT_ASSERT(a_no_overflow, (w_push_n != '0) |-> ((r_count + w_push_n) <= (PW + 1)'(DEPTH)), "output queue overflow")
    `VCFGT_ASSERT(a_drain_last, (w_pop && (r_count == 1) && (w_push_n == '0)) |=> !o_valid, "queue not empty after last word taken")
    `VCFGT_ASSERT(a_count_hold, ((w_push_n == '0) && !w_pop) |=> $stable(r_count), "queue count changed without traffic")

endmodule

/* rtl/vcf_genotype_line_parser.sv */
// Variant line parser: one line byte or one table write per input word.
// The words caused by a byte are written into the output queue before they reach the output.
// Throughput: one input word per cycle while the selection memory is idle and the output queue
// has room for two words; the output queue of four words sets how far the sides can drift.
// Reset: synchronous, active low; it clears all line state, then a clearing pass over all
// MAX_SAMPLE_COLUMNS entries zeroes the selection memory while no input word is taken.
`timescale 1ns / 1ps
`include "vcf_genotype_line_parser_defines.svh"

module vcf_genotype_line_parser #(
    parameter int MAX_SAMPLE_COLUMNS = vcfgt_pkg::MAX_SAMPLE_COLUMNS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // line_byte[7:0], sample_column[19:8], sample_selected[20]
    input  logic [0:0]  i_s_tuser,  // req_type[0]
    input  logic        i_s_tlast,  // end_of_line
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // chrom_byte[7:0], sample_ordinal[19:8], hap_first[20], hap_second[21],
    // genotype_unknown[22], genotype_unphased[23], record_position[54:24],
    // ref_base[62:55], alt_base[70:63], line_status[72:71]
    output logic [79:0] o_m_tdata,
    output logic [1:0]  o_m_tuser,  // result_kind[1:0]
    output logic        o_m_tlast   // last_of_item
);

    localparam int ADDR_W = (MAX_SAMPLE_COLUMNS > 1) ? $clog2(MAX_SAMPLE_COLUMNS) : 1;

    // Line state.
    logic [12:0] r_field,  n_field;
    logic [1:0]  r_bif,    n_bif;
    logic [30:0] r_pos,    n_pos;
    logic        r_pdone,  n_pdone;
    logic [7:0]  r_refb,   n_refb;
    logic [7:0]  r_altb,   n_altb;
    logic [7:0]  r_gt [3];
    logic [7:0]  n_gt [3];
    logic [1:0]  r_outc,   n_outc;
    logic [11:0] r_cnt,    n_cnt;

    logic        w_acc;
    logic        w_req;
    logic [7:0]  w_byte;
    logic        w_eol;
    logic [11:0] w_col;
    logic        w_sel_bit;
    logic        w_tbl_we;
    logic [31:0] w_raddr_full;
    logic        w_tbl_rdata;
    logic        w_tbl_busy;
    logic        w_in_range;
    logic        w_sel_now;
    logic        w_q_ready;
    logic [34:0] w_pos_next;
    vcfgt_pkg::t_push   w_push;
    vcfgt_pkg::t_result w_head;

    assign w_req     = i_s_tuser[0];
    assign w_byte    = i_s_tdata[7:0];
    assign w_col     = i_s_tdata[19:8];
    assign w_sel_bit = i_s_tdata[20];
    assign w_eol     = i_s_tlast;

    assign o_s_tready = !w_tbl_busy && w_q_ready;
    assign w_acc      = i_s_tvalid && o_s_tready;

    // Table writes beyond the memory are dropped.
    assign w_tbl_we = w_acc && (w_req == vcfgt_pkg::REQ_TABLE)
                      && (32'(w_col) < 32'(MAX_SAMPLE_COLUMNS));

    // Prefetch the selection bit of the field that will be current next cycle.
    assign w_raddr_full = 32'(n_field) - 32'(vcfgt_pkg::FIRST_SAMPLE_FIELD);

    // The current field is a sample column inside the table.
    assign w_in_range = (r_field >= vcfgt_pkg::FIRST_SAMPLE_FIELD)
        && ((32'(r_field) - 32'(vcfgt_pkg::FIRST_SAMPLE_FIELD)) < 32'(MAX_SAMPLE_COLUMNS));
    assign w_sel_now = w_in_range && w_tbl_rdata;

    // Position times ten plus the new digit.
    assign w_pos_next = ({4'd0, r_pos} << 3) + ({4'd0, r_pos} << 1)
                        + {31'd0, w_byte[3:0]};

    vcfgt_sel_table #(
        .DEPTH  (MAX_SAMPLE_COLUMNS),
        .ADDR_W (ADDR_W)
    ) u_sel_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_tbl_we),
        .i_waddr (ADDR_W'(w_col)),
        .i_wdata (w_sel_bit),
        .i_raddr (w_raddr_full[ADDR_W-1:0]),
        .o_rdata (w_tbl_rdata),
        .o_busy  (w_tbl_busy)
    );

    // Byte parsing: take the byte, close the field, then finish the record.
    always_comb begin
        n_field = r_field;
        n_bif   = r_bif;
        n_pos   = r_pos;
        n_pdone = r_pdone;
        n_refb  = r_refb;
        n_altb  = r_altb;
        n_gt    = r_gt;
        n_outc  = r_outc;
        n_cnt   = r_cnt;
        w_push  = '0;

        if (w_acc && (w_req == vcfgt_pkg::REQ_BYTE)) begin
            // A byte inside a field.
            if ((w_byte != vcfgt_pkg::CH_TAB) && (r_outc == vcfgt_pkg::ST_OK)) begin
                case (r_field)
                    vcfgt_pkg::FLD_CHROM: begin
                        w_push.r0.kind       = vcfgt_pkg::RK_CHROM;
                        w_push.r0.chrom_byte = w_byte;
                        w_push.cnt           = 2'd1;
                    end
                    vcfgt_pkg::FLD_POS: begin
                        if (!r_pdone) begin
                            if (w_byte inside {[vcfgt_pkg::CH_ZERO:vcfgt_pkg::CH_NINE]}) begin
                                if (w_pos_next > {4'd0, vcfgt_pkg::POS_MAX}) begin
                                    n_pos = vcfgt_pkg::POS_MAX;
                                end else begin
                                    n_pos = w_pos_next[30:0];
                                end
                            end else begin
                                n_pdone = 1'b1;
                            end
                        end
                    end
                    vcfgt_pkg::FLD_REF: begin
                        if (r_bif == 2'd0) begin
                            n_refb = w_byte;
                        end else begin
                            n_outc = vcfgt_pkg::ST_REJECT;
                        end
                    end
                    vcfgt_pkg::FLD_ALT: begin
                        if (r_bif == 2'd0) begin
                            n_altb = w_byte;
                        end else begin
                            n_outc = vcfgt_pkg::ST_REJECT;
                        end
                    end
                    vcfgt_pkg::FLD_FORMAT: begin
                        if (((r_bif == 2'd0) && (w_byte != vcfgt_pkg::CH_G))
                            || ((r_bif == 2'd1) && (w_byte != vcfgt_pkg::CH_T))) begin
                            n_outc = vcfgt_pkg::ST_FORMAT;
                        end
                    end
                    default: begin
                    end
                endcase
                if (r_bif != 2'd3) begin
                    n_gt[r_bif] = w_byte;
                    n_bif       = r_bif + 2'd1;
                end
            end

            // A tab or the end of the line closes the field.
            if ((w_byte == vcfgt_pkg::CH_TAB) || w_eol) begin
                if (n_outc == vcfgt_pkg::ST_OK) begin
                    if ((r_field == vcfgt_pkg::FLD_REF) && (n_bif == 2'd0)) begin
                        n_refb = vcfgt_pkg::CH_TAB;
                    end else if ((r_field == vcfgt_pkg::FLD_ALT) && (n_bif == 2'd0)) begin
                        n_altb = vcfgt_pkg::CH_TAB;
                    end else if ((r_field == vcfgt_pkg::FLD_FORMAT) && (n_bif < 2'd2)) begin
                        n_outc = vcfgt_pkg::ST_FORMAT;
                    end else if (w_sel_now) begin
                        w_push.r0.kind           = vcfgt_pkg::RK_GENO;
                        w_push.r0.sample_ordinal = r_cnt;
                        if (n_gt[0] == vcfgt_pkg::CH_DOT) begin
                            w_push.r0.unknown = 1'b1;
                        end else begin
                            w_push.r0.hap_first  = (n_gt[0] == vcfgt_pkg::CH_ONE);
                            w_push.r0.hap_second = (n_gt[2] == vcfgt_pkg::CH_ONE);
                            w_push.r0.unphased   = (n_gt[1] != vcfgt_pkg::CH_PIPE);
                        end
                        w_push.cnt = 2'd1;
                        n_cnt      = r_cnt + 12'd1;
                    end
                end
                n_gt[0] = '0;
                n_gt[1] = '0;
                n_gt[2] = '0;
                n_bif   = 2'd0;
            end

            // Move on to the next field after a tab.
            if ((w_byte == vcfgt_pkg::CH_TAB) && !w_eol && (r_field != vcfgt_pkg::FIELD_MAX)) begin
                n_field = r_field + 13'd1;
            end

            // The last byte gives the record word and clears the line.
            if (w_eol) begin
                if (w_push.cnt == 2'd0) begin
                    w_push.r0.kind     = vcfgt_pkg::RK_RECORD;
                    w_push.r0.position = n_pos;
                    w_push.r0.ref_base = n_refb;
                    w_push.r0.alt_base = n_altb;
                    w_push.r0.status   = n_outc;
                    w_push.r0.last     = 1'b1;
                    w_push.cnt         = 2'd1;
                end else begin
                    w_push.r1.kind     = vcfgt_pkg::RK_RECORD;
                    w_push.r1.position = n_pos;
                    w_push.r1.ref_base = n_refb;
                    w_push.r1.alt_base = n_altb;
                    w_push.r1.status   = n_outc;
                    w_push.r1.last     = 1'b1;
                    w_push.cnt         = 2'd2;
                end
                n_field = '0;
                n_bif   = '0;
                n_pos   = '0;
                n_pdone = 1'b0;
                n_refb  = '0;
                n_altb  = '0;
                n_gt[0] = '0;
                n_gt[1] = '0;
                n_gt[2] = '0;
                n_outc  = vcfgt_pkg::ST_OK;
                n_cnt   = '0;
            end else if (w_push.cnt == 2'd1) begin
                w_push.r0.last = 1'b1;
            end
        end
    end

    // Line state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field <= '0;
            r_bif   <= '0;
            r_pos   <= '0;
            r_pdone <= 1'b0;
            r_refb  <= '0;
            r_altb  <= '0;
            r_gt[0] <= '0;
            r_gt[1] <= '0;
            r_gt[2] <= '0;
            r_outc  <= vcfgt_pkg::ST_OK;
            r_cnt   <= '0;
        end else begin
            r_field <= n_field;
            r_bif   <= n_bif;
            r_pos   <= n_pos;
            r_pdone <= n_pdone;
            r_refb  <= n_refb;
            r_altb  <= n_altb;
            r_gt    <= n_gt;
            r_outc  <= n_outc;
            r_cnt   <= n_cnt;
        end
    end

    vcfgt_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .o_valid (o_m_tvalid),
        .o_head  (w_head),
        .i_ready (i_m_tready)
    );

    // Pack the head word onto the result stream.
    assign o_m_tdata = {7'd0, w_head.status, w_head.alt_base, w_head.ref_base,
                        w_head.position, w_head.unphased, w_head.unknown,
                        w_head.hap_second, w_head.hap_first, w_head.sample_ordinal,
                        w_head.chrom_byte};
    assign o_m_tuser = w_head.kind;
    assign o_m_tlast = w_head.last;

    `VCFGT_ASSERT(a_eol_clears, (w_acc && (w_req == vcfgt_pkg::REQ_BYTE) && w_eol) |=> ((r_field == '0) && (r_cnt == '0) && (r_outc == vcfgt_pkg::ST_OK)), "line state not cleared after end of line")
    `VCFGT_ASSERT(a_pair_order, (w_push.cnt == 2'd2) |-> ((w_push.r1.kind == vcfgt_pkg::RK_RECORD) && w_push.r1.last && !w_push.r0.last && (w_push.r0.kind != vcfgt_pkg::RK_RECORD)), "two words from one byte out of order")
    `VCFGT_ASSERT(a_unknown_zero, ((w_push.cnt != 2'd0) && w_push.r0.unknown) |-> (!w_push.r0.hap_first && !w_push.r0.hap_second && !w_push.r0.unphased), "unknown genotype with allele bits set")

endmodule
